### rtl/core/mbclk_pkg.sv
// ----------------------------------------------------------------------------
// mbclk_pkg
// Shared types and constants for the MIDI beat clock generator.
// ----------------------------------------------------------------------------
package mbclk_pkg;

  localparam int POS_W        = 48;
  localparam int BPM_W        = 10;
  localparam int RATE_W       = 18;
  localparam int RATE_X60_W   = 24;   // RATE_W bits times 60 fits in 24 bits
  localparam int TICKS_W      = 32;
  localparam int CFG_INDEX_W  = 1;
  localparam int CFG_DATA_W   = RATE_W;

  localparam logic [RATE_X60_W-1:0] SECONDS_PER_MINUTE = 24'd60;
  localparam logic [RATE_W-1:0]     RATE_HZ_RESET      = 18'd48000;

  localparam logic [CFG_INDEX_W-1:0] REG_CLOCK_ENABLE = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_RATE_HZ      = 1'b1;

  localparam logic [7:0] MIDI_SONG_POS = 8'hF2;
  localparam logic [7:0] MIDI_ZERO     = 8'h00;
  localparam logic [7:0] MIDI_START    = 8'hFA;
  localparam logic [7:0] MIDI_STOP     = 8'hFC;
  localparam logic [7:0] MIDI_CLOCK    = 8'hF8;

  typedef struct packed {
    logic             playing;
    logic [BPM_W-1:0] tempo_bpm;
    logic [POS_W-1:0] sample_position;
  } poll_t;

  typedef struct packed {
    logic [7:0]         midi_byte;
    logic               last;
    logic [TICKS_W-1:0] ticks_total;
  } midi_t;

  // classified poll handed from the front end to the back end
  typedef struct packed {
    logic             start;
    logic             stop;
    logic             ticks;
    logic [BPM_W-1:0] tempo_bpm;
    logic [POS_W-1:0] sample_position;
  } cmd_t;

endpackage

### rtl/core/mbclk_front.sv
// ----------------------------------------------------------------------------
// mbclk_front
// Accepts polls, tracks the play edge and queues work for the back end.
// ----------------------------------------------------------------------------
module mbclk_front import mbclk_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              poll_valid,
  output logic              poll_stall,
  input  poll_t             poll,
  input  logic              clock_enable,
  input  logic [RATE_W-1:0] rate_hz,
  input  logic              q_full,
  output logic              q_push,
  output cmd_t              q_cmd
);

  logic play_q;
  logic acc;
  logic active;

  assign poll_stall = q_full;
  assign acc        = poll_valid && !q_full;
  assign active     = acc && (rate_hz != '0) && clock_enable;

  always_comb begin
    q_cmd.start           = poll.playing && !play_q;
    q_cmd.stop            = !poll.playing && play_q;
    q_cmd.ticks           = poll.playing && (poll.tempo_bpm != '0);
    q_cmd.tempo_bpm       = poll.tempo_bpm;
    q_cmd.sample_position = poll.sample_position;
  end

  // polls that cause no bytes and no back-end state change are dropped here
  assign q_push = active && (q_cmd.start || q_cmd.stop || q_cmd.ticks);

  always_ff @(posedge clk) begin
    if (rst) begin
      play_q <= 1'b0;
    end else if (acc && (rate_hz != '0)) begin
      play_q <= clock_enable ? poll.playing : 1'b0;
    end
  end

endmodule

### rtl/core/mbclk_cmdq.sv
// ----------------------------------------------------------------------------
// mbclk_cmdq
// Two-entry request queue between the front end and the back end.
// ----------------------------------------------------------------------------
module mbclk_cmdq import mbclk_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t din,
  input  logic pop,
  output cmd_t dout,
  output logic full,
  output logic empty
);

  cmd_t       mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full  = (count == 2'd2);
  assign empty = (count == 2'd0);
  assign dout  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

### rtl/core/mbclk_div.sv
// ----------------------------------------------------------------------------
// mbclk_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mbclk_div import mbclk_pkg::*; #(
  parameter int NUM_W = 36,
  parameter int DEN_W = 15
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quo
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [DEN_W-1:0] rem;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [DEN_W:0]   trial;
  logic             fits;

  assign trial = {rem, quo[NUM_W-1]};
  assign fits  = (trial >= {1'b0, den});

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= num;
    end else if (busy) begin
      rem <= fits ? DEN_W'(trial - {1'b0, den}) : trial[DEN_W-1:0];
      quo <= {quo[NUM_W-2:0], fits};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(NUM_W);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

### rtl/core/mbclk_back.sv
// ----------------------------------------------------------------------------
// mbclk_back
// Computes the tick period and sends transport and clock bytes.
// ----------------------------------------------------------------------------
module mbclk_back import mbclk_pkg::*; #(
  parameter int MAX_TICKS_PER_ITEM = 16,
  parameter int FRACTION_BITS      = 12,
  parameter int TICKS_PER_QUARTER  = 24
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [RATE_W-1:0] rate_hz,
  input  logic              q_empty,
  input  cmd_t              q_cmd,
  output logic              q_pop,
  output logic              midi_valid,
  input  logic              midi_stall,
  output midi_t             midi
);

  localparam int TIME_W = POS_W + FRACTION_BITS;
  localparam int NUM_W  = RATE_X60_W + FRACTION_BITS;
  localparam int DEN_W  = BPM_W + $clog2(TICKS_PER_QUARTER + 1);
  localparam int TCNT_W = $clog2(MAX_TICKS_PER_ITEM + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_HDR  = 2'd2;
  localparam logic [1:0] ST_TICK = 2'd3;

  logic [1:0]         state;
  cmd_t               cmd;
  logic [NUM_W-1:0]   period;
  logic [TIME_W-1:0]  next_tick;
  logic [TICKS_W-1:0] tick_counter;
  logic [TCNT_W-1:0]  tick_cnt;
  logic [1:0]         hdr_idx;
  logic               start_div_q;

  logic [TIME_W-1:0]  now;
  logic [TIME_W:0]    sum;
  logic [TIME_W-1:0]  cand;
  logic               slot_free;
  logic               tick_due;
  logic               tick_last;
  logic               byte_go;
  logic               div_start;
  logic               div_done;
  logic [NUM_W-1:0]   div_num;
  logic [DEN_W-1:0]   div_den;
  logic [NUM_W-1:0]   div_quo;
  logic [RATE_X60_W-1:0] rate_x60;

  assign rate_x60  = RATE_X60_W'(rate_hz) * SECONDS_PER_MINUTE;
  assign div_num   = NUM_W'(rate_x60) << FRACTION_BITS;
  assign div_den   = DEN_W'(cmd.tempo_bpm) * DEN_W'(TICKS_PER_QUARTER);

  assign now       = TIME_W'(cmd.sample_position) << FRACTION_BITS;
  assign sum       = {1'b0, next_tick} + (TIME_W + 1)'(period);
  assign cand      = sum[TIME_W] ? '1 : sum[TIME_W-1:0];
  assign slot_free = !midi_valid || !midi_stall;
  assign tick_due  = (tick_cnt != TCNT_W'(MAX_TICKS_PER_ITEM)) && (next_tick <= now);
  assign tick_last = (tick_cnt == TCNT_W'(MAX_TICKS_PER_ITEM - 1)) || (cand > now);
  assign byte_go   = slot_free && ((state == ST_HDR) || ((state == ST_TICK) && tick_due));

  assign q_pop     = (state == ST_IDLE) && !q_empty;

  // divider kicks off the cycle after the request is latched
  assign div_start = start_div_q;

  mbclk_div #(
    .NUM_W (NUM_W),
    .DEN_W (DEN_W)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cmd <= q_cmd;
    end
    if (div_done) begin
      period <= div_quo;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      start_div_q  <= 1'b0;
      next_tick    <= '0;
      tick_counter <= '0;
      tick_cnt     <= '0;
      hdr_idx      <= '0;
      midi_valid   <= 1'b0;
    end else begin
      start_div_q <= 1'b0;
      if (byte_go) begin
        midi_valid <= 1'b1;
      end else if (midi_valid && !midi_stall) begin
        midi_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          tick_cnt <= '0;
          hdr_idx  <= '0;
          if (q_pop) begin
            if (q_cmd.start) begin
              next_tick <= TIME_W'(q_cmd.sample_position) << FRACTION_BITS;
            end
            if (q_cmd.ticks) begin
              start_div_q <= 1'b1;
              state       <= ST_DIV;
            end else begin
              state <= ST_HDR;
            end
          end
        end
        ST_DIV: begin
          if (div_done) begin
            state <= (cmd.start || cmd.stop) ? ST_HDR : ST_TICK;
          end
        end
        ST_HDR: begin
          if (slot_free) begin
            midi.ticks_total <= tick_counter;
            midi.last        <= cmd.stop || ((hdr_idx == 2'd3) && !cmd.ticks);
            if (cmd.stop) begin
              midi.midi_byte <= MIDI_STOP;
              state          <= ST_IDLE;
            end else begin
              hdr_idx <= hdr_idx + 2'd1;
              case (hdr_idx)
                2'd0: midi.midi_byte <= MIDI_SONG_POS;
                2'd1: midi.midi_byte <= MIDI_ZERO;
                2'd2: midi.midi_byte <= MIDI_ZERO;
                default: begin
                  midi.midi_byte <= MIDI_START;
                  state          <= cmd.ticks ? ST_TICK : ST_IDLE;
                end
              endcase
            end
          end
        end
        ST_TICK: begin
          if (!tick_due) begin
            state <= ST_IDLE;
          end else if (slot_free) begin
            midi.midi_byte   <= MIDI_CLOCK;
            midi.last        <= tick_last;
            midi.ticks_total <= tick_counter + TICKS_W'(1);
            tick_counter     <= tick_counter + TICKS_W'(1);
            next_tick        <= cand;
            tick_cnt         <= tick_cnt + TCNT_W'(1);
            if (tick_last) begin
              state <= ST_IDLE;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

### rtl/core/midi_beat_clock_generator_core.sv
// ----------------------------------------------------------------------------
// midi_beat_clock_generator_core
// MIDI beat clock generator, 24 pulses per quarter note, from transport polls.
// ----------------------------------------------------------------------------
// Usage:
//   poll channel (poll_valid / poll_stall / poll): one request per transport
//   poll carrying play state, tempo and the current sample position.
//   midi channel (midi_valid / midi_stall / midi): one MIDI byte per request,
//   with last set on the final byte a poll causes and the running tick count.
//   cfg_write / cfg_index / cfg_data write clock enable and sample rate; write
//   them only while no poll is in flight.
// Timing: the front end takes a poll per cycle while its two-entry queue has
//   room. A poll that sends clock bytes first runs the tick period divider,
//   then emits one byte per cycle the output register is free: up to
//   4 + MAX_TICKS_PER_ITEM bytes. A start or stop only poll skips the
//   divider. The back end pops the next poll only once it is idle again.
// Reset: clock disabled, sample rate 48000, not playing, tick count zero.
// A stalled midi byte holds; the back end waits and the queue then fills.
// ----------------------------------------------------------------------------
module midi_beat_clock_generator_core import mbclk_pkg::*; #(
  parameter int MAX_TICKS_PER_ITEM = 16,
  parameter int FRACTION_BITS      = 12,
  parameter int TICKS_PER_QUARTER  = 24
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   poll_valid,
  output logic                   poll_stall,
  input  poll_t                  poll,
  output logic                   midi_valid,
  input  logic                   midi_stall,
  output midi_t                  midi
);

  logic              clock_enable;
  logic [RATE_W-1:0] rate_hz;
  logic              q_full;
  logic              q_empty;
  logic              q_push;
  logic              q_pop;
  cmd_t              q_din;
  cmd_t              q_dout;

  always_ff @(posedge clk) begin
    if (rst) begin
      clock_enable <= 1'b0;
      rate_hz      <= RATE_HZ_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_CLOCK_ENABLE: clock_enable <= cfg_data[0];
        REG_RATE_HZ:      rate_hz      <= cfg_data;
        default: ;
      endcase
    end
  end

  mbclk_front u_front (
    .clk          (clk),
    .rst          (rst),
    .poll_valid   (poll_valid),
    .poll_stall   (poll_stall),
    .poll         (poll),
    .clock_enable (clock_enable),
    .rate_hz      (rate_hz),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_cmd        (q_din)
  );

  mbclk_cmdq u_cmdq (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .din   (q_din),
    .pop   (q_pop),
    .dout  (q_dout),
    .full  (q_full),
    .empty (q_empty)
  );

  mbclk_back #(
    .MAX_TICKS_PER_ITEM (MAX_TICKS_PER_ITEM),
    .FRACTION_BITS      (FRACTION_BITS),
    .TICKS_PER_QUARTER  (TICKS_PER_QUARTER)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .rate_hz     (rate_hz),
    .q_empty     (q_empty),
    .q_cmd       (q_dout),
    .q_pop       (q_pop),
    .midi_valid  (midi_valid),
    .midi_stall  (midi_stall),
    .midi        (midi)
  );

endmodule
